/* src/cptb_pkg.sv */
// Shared types and constants for the call path trace buffer.
// No dependencies; every other file of the block refers to this package.
package cptb_pkg;

  localparam int CYCLE_W         = 64;
  localparam int ADDR_W          = 32;
  localparam int LIMIT_W         = 6;
  localparam int HISTORY_DEPTH_D = 32;
  localparam int MAX_RESULTS     = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [0:0] {
    FUNC_RECORD    = 1'b0,
    FUNC_BACKTRACE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_DATA,
    WALK_FINISH
  } walk_state_t;

  // One stored transfer.
  typedef struct packed {
    logic               is_entry;
    logic [CYCLE_W-1:0] cycle;
    logic [ADDR_W-1:0]  target;
    logic [ADDR_W-1:0]  source;
  } entry_t;

endpackage

/* src/cptb_if.sv */
// Valid/ready channel interfaces for command and response beats.
// Depends on cptb_pkg for the field widths.
interface cptb_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [0:0]                    func;
  logic [cptb_pkg::CYCLE_W-1:0]  cycle;
  logic [cptb_pkg::ADDR_W-1:0]   target_address;
  logic [cptb_pkg::ADDR_W-1:0]   source_address;
  logic                          is_entry;

  modport source(output valid, func, cycle, target_address, source_address, is_entry,
                 input ready);
  modport sink(input valid, func, cycle, target_address, source_address, is_entry,
               output ready);
endinterface

interface cptb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [cptb_pkg::CYCLE_W-1:0]  out_cycle;
  logic [cptb_pkg::ADDR_W-1:0]   out_target;
  logic [cptb_pkg::ADDR_W-1:0]   out_source;
  logic                          last;

  modport source(output valid, found, out_cycle, out_target, out_source, last,
                 input ready);
  modport sink(input valid, found, out_cycle, out_target, out_source, last,
               output ready);
endinterface

/* src/cptb_mem.sv */
// History ring storage: one write port, one read port, registered read data.
// Depends on cptb_pkg for the entry type.
module cptb_mem #(
  parameter int DEPTH = cptb_pkg::HISTORY_DEPTH_D
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  cptb_pkg::entry_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output cptb_pkg::entry_t         rdata
);

  cptb_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data only moves on a read, so a stalled walk keeps its entry.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/cptb_walk.sv */
// Backtrace sequencer: reads the history newest first, applies the skip
// count and drives the response register. Depends on cptb_pkg, cptb_if.
module cptb_walk #(
  parameter int DEPTH = cptb_pkg::HISTORY_DEPTH_D
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [$clog2(DEPTH)-1:0]   start_ptr,
  input  logic [$clog2(DEPTH+1)-1:0] start_count,
  output logic                       busy,
  output logic                       re,
  output logic [$clog2(DEPTH)-1:0]   raddr,
  input  cptb_pkg::entry_t           rdata,
  cptb_rsp_if.source                 rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $clog2(cptb_pkg::MAX_RESULTS + 1);

  cptb_pkg::walk_state_t state, state_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [CW-1:0]         remaining, remaining_next;
  logic [CW-1:0]         skips, skips_next;
  logic [EW-1:0]         emitted, emitted_next;
  logic                  pend_valid, pend_valid_next;
  cptb_pkg::entry_t      pend, pend_next;

  logic                         out_valid, out_valid_next;
  logic                         out_found, out_found_next;
  logic                         out_last, out_last_next;
  logic [cptb_pkg::CYCLE_W-1:0] out_cycle, out_cycle_next;
  logic [cptb_pkg::ADDR_W-1:0]  out_target, out_target_next;
  logic [cptb_pkg::ADDR_W-1:0]  out_source, out_source_next;

  logic out_free;
  logic qual;
  logic done;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  assign out_free = !out_valid || rsp.ready;
  assign qual     = rdata.is_entry && (skips == '0);
  assign done     = (remaining == '0) ||
                    (qual && (emitted == EW'(cptb_pkg::MAX_RESULTS - 1)));

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    remaining_next  = remaining;
    skips_next      = skips;
    emitted_next    = emitted;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    out_valid_next  = out_valid && !rsp.ready;
    out_found_next  = out_found;
    out_last_next   = out_last;
    out_cycle_next  = out_cycle;
    out_target_next = out_target;
    out_source_next = out_source;
    re              = 1'b0;
    raddr           = ptr;

    unique case (state)
      cptb_pkg::WALK_IDLE: begin
        if (start) begin
          skips_next      = '0;
          emitted_next    = '0;
          pend_valid_next = 1'b0;
          if (start_count == '0) begin
            state_next = cptb_pkg::WALK_FINISH;
          end else begin
            re             = 1'b1;
            raddr          = start_ptr;
            ptr_next       = ptr_dec(start_ptr);
            remaining_next = start_count - CW'(1);
            state_next     = cptb_pkg::WALK_DATA;
          end
        end
      end

      cptb_pkg::WALK_DATA: begin
        // A new hit must first push the held one out; wait for a free slot.
        if (!(qual && pend_valid && !out_free)) begin
          if (!rdata.is_entry) begin
            skips_next = skips + CW'(1);
          end else if (skips != '0) begin
            skips_next = skips - CW'(1);
          end else begin
            if (pend_valid) begin
              out_valid_next  = 1'b1;
              out_found_next  = 1'b1;
              out_last_next   = 1'b0;
              out_cycle_next  = pend.cycle;
              out_target_next = pend.target;
              out_source_next = pend.source;
            end
            pend_next       = rdata;
            pend_valid_next = 1'b1;
            emitted_next    = emitted + EW'(1);
          end
          if (done) begin
            state_next = cptb_pkg::WALK_FINISH;
          end else begin
            re             = 1'b1;
            raddr          = ptr;
            ptr_next       = ptr_dec(ptr);
            remaining_next = remaining - CW'(1);
          end
        end
      end

      cptb_pkg::WALK_FINISH: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_found_next  = pend_valid;
          out_last_next   = 1'b1;
          out_cycle_next  = pend_valid ? pend.cycle  : '0;
          out_target_next = pend_valid ? pend.target : '0;
          out_source_next = pend_valid ? pend.source : '0;
          state_next      = cptb_pkg::WALK_IDLE;
        end
      end

      default: state_next = cptb_pkg::WALK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cptb_pkg::WALK_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    remaining  <= remaining_next;
    skips      <= skips_next;
    emitted    <= emitted_next;
    pend       <= pend_next;
    out_found  <= out_found_next;
    out_last   <= out_last_next;
    out_cycle  <= out_cycle_next;
    out_target <= out_target_next;
    out_source <= out_source_next;
  end

  assign busy           = (state != cptb_pkg::WALK_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.last       = out_last;
  assign rsp.out_cycle  = out_cycle;
  assign rsp.out_target = out_target;
  assign rsp.out_source = out_source;

endmodule

/* src/call_path_trace_buffer.sv */
// Call path trace buffer: keeps the most recent history_limit procedure
// transfers (cycle, target, source, call entry or return) in a ring memory
// and, on a backtrace command, reports the call entries still open, newest
// first, with the final response beat marked by last. A record command
// never holds off the next command. A backtrace starts, visits one stored
// transfer per cycle while the response side does not stall it, since the
// ring memory has a single read port, and then closes before the next
// command is taken. No commands are taken while a backtrace walks. A
// response beat waits in its own register, so the block goes on taking
// record commands while it is unread. The ring needs no clearing after
// reset: only slots already written are ever read.
// Depends on cptb_pkg, cptb_if, cptb_mem and cptb_walk.
module call_path_trace_buffer #(
  parameter int HISTORY_DEPTH = cptb_pkg::HISTORY_DEPTH_D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cptb_pkg::LIMIT_W-1:0] cfg_wdata,
  cptb_cmd_if.sink                     cmd,
  cptb_rsp_if.source                   rsp
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = cptb_pkg::LIMIT_W + 1;

  // Limit register, write pointer and fill count of the ring.
  logic [cptb_pkg::LIMIT_W-1:0] history_limit;
  logic [AW-1:0]                write_pointer, write_pointer_next;
  logic [CW-1:0]                entry_count, entry_count_next;

  logic [CW-1:0]    eff_limit;
  logic [CW-1:0]    new_limit;
  logic [AW-1:0]    newest;
  logic             cmd_beat;
  logic             rec_we;
  logic             walk_start;
  logic             walk_busy;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  cptb_pkg::entry_t mem_wdata;
  cptb_pkg::entry_t mem_rdata;

  // A zero limit counts as one, and a limit beyond the ring as the ring size.
  function automatic logic [CW-1:0] clamp_limit(input logic [cptb_pkg::LIMIT_W-1:0] raw);
    if (raw == '0) begin
      clamp_limit = CW'(1);
    end else if ({1'b0, raw} > CMPW'(HISTORY_DEPTH)) begin
      clamp_limit = CW'(HISTORY_DEPTH);
    end else begin
      clamp_limit = CW'(raw);
    end
  endfunction

  assign eff_limit = clamp_limit(history_limit);
  assign new_limit = clamp_limit(cfg_wdata);

  // Commands are held off only while a backtrace is walking the ring.
  assign cmd.ready  = !walk_busy;
  assign cmd_beat   = cmd.valid && cmd.ready;
  assign rec_we     = cmd_beat && (cmd.func == cptb_pkg::FUNC_RECORD);
  assign walk_start = cmd_beat && (cmd.func == cptb_pkg::FUNC_BACKTRACE);

  assign mem_wdata.is_entry = cmd.is_entry;
  assign mem_wdata.cycle    = cmd.cycle;
  assign mem_wdata.target   = cmd.target_address;
  assign mem_wdata.source   = cmd.source_address;

  // The newest transfer sits just behind the write pointer.
  assign newest = (write_pointer == '0) ? AW'(HISTORY_DEPTH - 1) : write_pointer - AW'(1);

  always_comb begin
    write_pointer_next = write_pointer;
    entry_count_next   = entry_count;
    if (rec_we) begin
      write_pointer_next = (write_pointer == AW'(HISTORY_DEPTH - 1)) ?
                           '0 : write_pointer + AW'(1);
      if (entry_count < eff_limit) begin
        entry_count_next = entry_count + CW'(1);
      end else begin
        entry_count_next = eff_limit;
      end
    end
    if (cfg_we) begin
      // Lowering the limit drops the oldest transfers for good.
      if (entry_count_next > new_limit) begin
        entry_count_next = new_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit <= cptb_pkg::LIMIT_RESET;
      write_pointer <= '0;
      entry_count   <= '0;
    end else begin
      if (cfg_we) begin
        history_limit <= cfg_wdata;
      end
      write_pointer <= write_pointer_next;
      entry_count   <= entry_count_next;
    end
  end

  cptb_mem #(
    .DEPTH(HISTORY_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (rec_we),
    .waddr(write_pointer),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  cptb_walk #(
    .DEPTH(HISTORY_DEPTH)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .start      (walk_start),
    .start_ptr  (newest),
    .start_count(entry_count),
    .busy       (walk_busy),
    .re         (mem_re),
    .raddr      (mem_raddr),
    .rdata      (mem_rdata),
    .rsp        (rsp)
  );

  // The fill count never runs past the limit in force.
  assert property (@(posedge clk) disable iff (rst) entry_count <= eff_limit)
    else $error("entry count exceeds the history limit");

  // The write pointer always names a slot of the ring.
  assert property (@(posedge clk) disable iff (rst) write_pointer <= AW'(HISTORY_DEPTH - 1))
    else $error("write pointer outside the ring");

  // A backtrace beat always starts a walk in the next cycle.
  assert property (@(posedge clk) disable iff (rst) walk_start |=> walk_busy)
    else $error("backtrace accepted but the walk did not start");

  // The ring is never written while a walk reads it.
  assert property (@(posedge clk) disable iff (rst) walk_busy |-> !rec_we)
    else $error("ring written during a backtrace walk");

endmodule

/* tb/sv/cptb_tb_pkg.sv */
// Checking side of the call path trace buffer testbench: command and frame types
// and a scoreboard class that predicts backtrace beats and checks them in order.
// Depends on cptb_pkg for the widths, the command enum and the stored-entry type.
package cptb_tb_pkg;
  import cptb_pkg::*;

  typedef struct {
    func_t               func;
    logic [CYCLE_W-1:0]  cycle;
    logic [ADDR_W-1:0]   target;
    logic [ADDR_W-1:0]   source;
    logic                is_entry;
  } command_t;

  typedef struct {
    logic                found;
    logic [CYCLE_W-1:0]  cycle;
    logic [ADDR_W-1:0]   target;
    logic [ADDR_W-1:0]   source;
    logic                last;
  } frame_t;

  class call_history_scoreboard;
    entry_t              history[HISTORY_DEPTH_D];
    int unsigned         head;
    int unsigned         held;
    logic [LIMIT_W-1:0]  limit;
    frame_t              expected_frames[$];
    int unsigned         mismatch_count;

    function new();
      head           = 0;
      held           = 0;
      limit          = LIMIT_RESET;
      mismatch_count = 0;
    endfunction

    // A limit of zero keeps one transfer; anything above the ring size keeps the ring.
    function int unsigned kept_depth();
      int unsigned lim;
      lim = limit;
      if (lim == 0) lim = 1;
      if (lim > HISTORY_DEPTH_D) lim = HISTORY_DEPTH_D;
      return lim;
    endfunction

    // Lowering the limit drops the oldest transfers for good.
    function void write_limit(logic [LIMIT_W-1:0] value);
      limit = value;
      if (held > kept_depth()) held = kept_depth();
    endfunction

    function void note_command(command_t c);
      int unsigned lim;
      int unsigned n;
      int unsigned skips;
      int unsigned idx;
      frame_t      walk[$];
      frame_t      f;
      lim = kept_depth();
      if (c.func == FUNC_RECORD) begin
        history[head] = '{is_entry: c.is_entry, cycle: c.cycle,
                          target: c.target, source: c.source};
        head = (head + 1) % HISTORY_DEPTH_D;
        if (held < lim) held++;
        return;
      end
      // Walk newest to oldest; each return cancels the next older call entry.
      n     = (held < lim) ? held : lim;
      skips = 0;
      for (int unsigned i = 0; i < n && walk.size() < MAX_RESULTS; i++) begin
        idx = (head + 2 * HISTORY_DEPTH_D - 1 - i) % HISTORY_DEPTH_D;
        if (!history[idx].is_entry) begin
          skips++;
        end else if (skips != 0) begin
          skips--;
        end else begin
          f = '{found: 1'b1, cycle: history[idx].cycle,
                target: history[idx].target, source: history[idx].source,
                last: 1'b0};
          walk.insert(walk.size(), f);
        end
      end
      if (walk.size() == 0) begin
        f = '{found: 1'b0, cycle: '0, target: '0, source: '0, last: 1'b1};
        walk.insert(0, f);
      end else begin
        walk[walk.size() - 1].last = 1'b1;
      end
      foreach (walk[k]) expected_frames.insert(expected_frames.size(), walk[k]);
    endfunction

    function void check_result(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected beat: found=%0b cycle=%h target=%h source=%h last=%0b",
                   got.found, got.cycle, got.target, got.source, got.last);
        end
        return;
      end
      want = expected_frames[0];
      expected_frames.delete(0);
      if (got.found !== want.found || got.cycle !== want.cycle ||
          got.target !== want.target || got.source !== want.source ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: expected found=%0b cycle=%h target=%h source=%h last=%0b",
                   want.found, want.cycle, want.target, want.source, want.last);
          $display("          actual   found=%0b cycle=%h target=%h source=%h last=%0b",
                   got.found, got.cycle, got.target, got.source, got.last);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction
  endclass

endpackage

/* tb/sv/call_path_trace_buffer_test.sv */
// Top-level testbench for call_path_trace_buffer: directed and random record and
// backtrace commands, history limit changes and handshake pressure on both channels.
// Depends on cptb_pkg, cptb_if, the block itself and cptb_tb_pkg.
module call_path_trace_buffer_test;
  import cptb_pkg::*;
  import cptb_tb_pkg::*;

  // A backtrace walks at most the whole ring before it closes, so these quiet
  // cycles after the last beat leave the block idle.
  localparam int SETTLE_CYCLES = HISTORY_DEPTH_D + 4;
  // Far above the slowest legal run.
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int BACKTRACE_PCT = 12;
  localparam int ENTRY_PCT     = 65;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  cptb_cmd_if cmd_bus ();
  cptb_rsp_if rsp_bus ();

  call_history_scoreboard scoreboard;

  // Knobs shared between the stimulus process and the response-side process.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_request  = 0;

  call_path_trace_buffer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd_bus),
    .rsp       (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The whole run is bounded; a hang anywhere ends here as a failure.
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Response side. Ready changes only at the falling edge. A long hold-off, when
  // requested, is counted down here so that the sender keeps offering commands
  // meanwhile and the block has to back up and stall its command channel.
  initial begin : response_side
    int unsigned hold_left;
    hold_left     = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every response beat taken at a rising edge is checked against the oldest
  // predicted frame.
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      scoreboard.check_result('{found: rsp_bus.found, cycle: rsp_bus.out_cycle,
                                target: rsp_bus.out_target, source: rsp_bus.out_source,
                                last: rsp_bus.last});
    end
  end

  // Mostly full-range random values, with the all-zeros and all-ones corners
  // turning up now and then. Callers take the low bits they need.
  function automatic logic [CYCLE_W-1:0] pick_bits();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Addresses arrive at full cycle width and keep only their low bits.
  function automatic command_t make_command(func_t func, logic [CYCLE_W-1:0] cycle,
                                            logic [CYCLE_W-1:0] target,
                                            logic [CYCLE_W-1:0] source, logic is_entry);
    command_t c;
    c.func     = func;
    c.cycle    = cycle;
    c.target   = target[ADDR_W-1:0];
    c.source   = source[ADDR_W-1:0];
    c.is_entry = is_entry;
    return c;
  endfunction

  // Backtraces carry random fields too: the block must ignore them.
  function automatic command_t random_command();
    func_t func;
    func = ($urandom_range(99) < BACKTRACE_PCT) ? FUNC_BACKTRACE : FUNC_RECORD;
    return make_command(func, pick_bits(), pick_bits(), pick_bits(),
                        $urandom_range(99) < ENTRY_PCT);
  endfunction

  // Offers one command beat, idling first at the current rate, and holds it
  // until the block takes it. Valid is left high so back-to-back beats need
  // no bubble; the quiet task lowers it.
  task automatic send_command(command_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.func           <= c.func;
    cmd_bus.cycle          <= c.cycle;
    cmd_bus.target_address <= c.target;
    cmd_bus.source_address <= c.source;
    cmd_bus.is_entry       <= c.is_entry;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    scoreboard.note_command(c);
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) send_command(random_command());
  endtask

  // Stops offering commands, waits for every predicted frame and then lets the
  // block finish whatever walk it may still be closing.
  task automatic wait_until_quiet();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The history limit is only ever changed while the block is idle.
  task automatic set_history_limit(logic [LIMIT_W-1:0] value);
    wait_until_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    scoreboard.write_limit(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [LIMIT_W-1:0] phase_limits[8];
    int unsigned        idle_table[4];
    int unsigned        stall_table[4];

    scoreboard             = new();
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.func           = FUNC_RECORD;
    cmd_bus.cycle          = '0;
    cmd_bus.target_address = '0;
    cmd_bus.source_address = '0;
    cmd_bus.is_entry       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A backtrace straight after reset finds nothing and must
    // return the single empty beat; its own fields are all ones and ignored.
    send_command(make_command(FUNC_BACKTRACE, '1, '1, '1, 1'b1));
    // Two calls at the field extremes, then a return that cancels the newer one,
    // so only the all-zeros call is reported.
    send_command(make_command(FUNC_RECORD, '0, '0, '0, 1'b1));
    send_command(make_command(FUNC_RECORD, '1, '1, '1, 1'b1));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b0));
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));
    // A second return cancels the remaining call: the history holds entries but
    // none qualifies, which again gives the empty beat.
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b0));
    send_command(make_command(FUNC_BACKTRACE, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    // Three open calls come back newest first.
    repeat (3) begin
      send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    end
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));
    // Lowering the limit to one discards everything but the newest transfer.
    set_history_limit(6'd1);
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b0));
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));
    // A limit of zero behaves as a limit of one.
    set_history_limit(6'd0);
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));
    // Raising the limit past the ring size clamps it, and the discarded
    // transfers do not reappear.
    set_history_limit(6'd63);
    send_command(make_command(FUNC_BACKTRACE, '1, '1, '1, 1'b1));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b0));
    send_command(make_command(FUNC_RECORD, pick_bits(), pick_bits(), pick_bits(), 1'b1));
    send_command(make_command(FUNC_BACKTRACE, '0, '0, '0, 1'b0));

    // Random part: four handshake phases (none, sender idle, receiver stalling,
    // both lightly), each under two history limits. Records dominate, so the
    // ring wraps many times and full-depth backtraces of up to 32 beats occur.
    phase_limits    = '{6'd32, 6'd1, 6'd63, 6'd3, 6'd0, 6'd20, 6'd32, 6'd2};
    phase_limits[5] = LIMIT_W'($urandom_range(63));
    idle_table      = '{0, 79, 0, 9};
    stall_table     = '{0, 0, 79, 9};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_table[p];
      stall_pct     = stall_table[p];
      for (int k = 0; k < 2; k++) begin
        set_history_limit(phase_limits[2 * p + k]);
        run_random(45);
      end
    end

    // Back-pressure: the receiver holds off for a long stretch while commands
    // keep coming, so a backtrace walk stalls and the command channel backs up.
    send_idle_pct = 0;
    stall_pct     = 0;
    set_history_limit(6'd32);
    hold_request = HOLD_CYCLES;
    run_random(40);
    // The sender then pauses until every predicted beat has been taken.
    wait_until_quiet();
    send_idle_pct = 20;
    stall_pct     = 30;
    run_random(20);

    wait_until_quiet();
    if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* call_path_trace_buffer.f */
src/cptb_pkg.sv
src/cptb_if.sv
src/cptb_mem.sv
src/cptb_walk.sv
src/call_path_trace_buffer.sv
tb/sv/cptb_tb_pkg.sv
tb/sv/call_path_trace_buffer_test.sv
